// ===== rtl/dbh_pkg.sv =====
// Shared types, constants and helpers of the dual byte hash fingerprint block.
package dbh_pkg;

  localparam int DIM_BITS  = 12;
  localparam int CfgW      = 12;
  localparam int CfgIdxW   = 2;
  localparam int HashW     = 64;
  localparam int CountW    = 26;
  localparam int DimWordW  = 32;
  localparam int HdrIdxW   = 3;

  localparam logic [HashW-1:0]    FnvOffset = 64'hCBF2_9CE4_8422_2325;
  localparam logic [HashW-1:0]    Golden    = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [CountW-1:0]   CountMax  = {CountW{1'b1}};
  localparam logic [HdrIdxW-1:0]  HdrLast   = {HdrIdxW{1'b1}};
  localparam logic [DimWordW-1:0] DimMask   = DimWordW'((64'd1 << DIM_BITS) - 64'd1);

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [HashW-1:0]  primary_hash;
    logic [HashW-1:0]  secondary_hash;
    logic [CountW-1:0] byte_total;
    logic              size_error;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FOLD,
    ST_FINISH
  } state_e;

  // Steps of one byte fold through the shared adder.
  typedef enum logic [3:0] {
    STEP_F0,
    STEP_F1,
    STEP_F2,
    STEP_F3,
    STEP_F4,
    STEP_F5,
    STEP_C0,
    STEP_C1,
    STEP_C2
  } step_e;

  typedef struct packed {
    logic  init;
    logic  run;
    step_e step;
  } fold_ctrl_t;

  function automatic logic [DimWordW-1:0] dim_value(input logic [CfgW-1:0] r);
    dim_value = DimWordW'(r) & DimMask;
  endfunction

endpackage

// ===== rtl/dbh_fold_unit.sv =====
// Hash state registers and the shared 64-bit adder that folds one byte per step sequence.
module dbh_fold_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dbh_pkg::fold_ctrl_t     ctrl_i,
  input  logic [7:0]              byte_i,
  output logic [dbh_pkg::HashW-1:0] fnv_o,
  output logic [dbh_pkg::HashW-1:0] comb_o
);
  import dbh_pkg::*;

  logic [HashW-1:0] fnv_q, fnv_d;
  logic [HashW-1:0] comb_q, comb_d;
  logic [HashW-1:0] acc_q, acc_d;
  logic [HashW-1:0] t_val;
  logic [HashW-1:0] op_a, op_b, sum;

  // FNV prime is 2^40 + 0x1B3, so the product is a chain of shifted adds of t.
  assign t_val = fnv_q ^ HashW'(byte_i);
  assign sum   = op_a + op_b;

  always_comb begin
    op_a = acc_q;
    op_b = '0;
    case (ctrl_i.step)
      STEP_F0: begin
        op_a = t_val;
        op_b = t_val << 1;
      end
      STEP_F1: op_b = t_val << 4;
      STEP_F2: op_b = t_val << 5;
      STEP_F3: op_b = t_val << 7;
      STEP_F4: op_b = t_val << 8;
      STEP_F5: op_b = t_val << 40;
      STEP_C0: begin
        op_a = HashW'(byte_i);
        op_b = Golden;
      end
      STEP_C1: op_b = comb_q << 6;
      STEP_C2: op_b = comb_q >> 2;
      default: op_b = '0;
    endcase
  end

  always_comb begin
    fnv_d  = fnv_q;
    comb_d = comb_q;
    acc_d  = acc_q;
    if (ctrl_i.init) begin
      fnv_d  = FnvOffset;
      comb_d = Golden;
    end else if (ctrl_i.run) begin
      case (ctrl_i.step)
        STEP_F5: fnv_d  = sum;
        STEP_C2: comb_d = comb_q ^ sum;
        default: acc_d  = sum;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fnv_q  <= '0;
      comb_q <= '0;
    end else begin
      fnv_q  <= fnv_d;
      comb_q <= comb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign fnv_o  = fnv_q;
  assign comb_o = comb_q;

endmodule

// ===== rtl/dual_byte_hash_fingerprint_top.sv =====
// Top level of the dual byte hash fingerprint block: sequencer, config and result register.
//
// The block fingerprints an RGBA byte stream with a 64-bit FNV-1a hash and a 64-bit
// golden-ratio combine hash. At the first word of a message it folds eight header
// bytes (width and height, alternating, least significant byte first) before the
// pixel byte; the word flagged last_byte closes the message and produces one result
// word holding both hashes and the pixel byte count, or zeros with size_error set
// when a dimension is zero or the count is not width*height*4. All folding goes
// through one shared 64-bit adder: each byte takes nine adder steps (six for the
// FNV prime product, three for the combine hash). The first word of a message folds
// the header bytes and then its pixel byte, other words the pixel byte alone; the
// last word then forms the result; in_stall_o stays high until the block is idle.
// The result sits in an output register, so a new message may start while the
// previous result waits; only the result step waits for that register to drain.
// The header uses the dimensions present at the first word of a message, the size
// check those present at the last word. The config port is always ready and is
// to be written only while the block is idle.
module dual_byte_hash_fingerprint_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  dbh_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dbh_pkg::out_word_t             out_word_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dbh_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [dbh_pkg::CfgW-1:0]       cfg_data_i
);
  import dbh_pkg::*;

  state_e state_q, state_d;
  step_e  step_q, step_d;

  logic [CfgW-1:0]     width_q, height_q;
  logic [DimWordW-1:0] hdr_w_q, hdr_h_q;
  logic                hdr_q;
  logic [HdrIdxW-1:0]  hdr_idx_q;
  logic                inside_q;
  logic [CountW-1:0]   bytes_q;
  logic [7:0]          data_q;
  logic                last_q;
  logic                out_valid_q;
  out_word_t           out_word_q, out_word_d;

  logic       accept;
  logic       step_done;
  logic       out_load;
  logic [7:0] hdr_byte;
  logic [7:0] cur_byte;
  fold_ctrl_t fold_ctrl;

  logic [HashW-1:0]    fnv_val, comb_val;
  logic [DimWordW-1:0] chk_w, chk_h;
  logic [DimWordW-1:0] prod;
  logic [CountW+7:0]   expected;
  logic                size_err;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign step_done   = (step_q == STEP_C2);

  // Header bytes go w0 h0 w1 h1 w2 h2 w3 h3.
  always_comb begin
    if (hdr_idx_q[0]) begin
      hdr_byte = hdr_h_q[{hdr_idx_q[2:1], 3'b000} +: 8];
    end else begin
      hdr_byte = hdr_w_q[{hdr_idx_q[2:1], 3'b000} +: 8];
    end
    cur_byte = hdr_q ? hdr_byte : data_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (step_done && !hdr_q) begin
          state_d = last_q ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall_o     = 1'b1;
    out_load       = 1'b0;
    fold_ctrl.init = 1'b0;
    fold_ctrl.run  = 1'b0;
    fold_ctrl.step = step_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        fold_ctrl.init = accept && !inside_q;
      end
      ST_FOLD:   fold_ctrl.run = 1'b1;
      ST_FINISH: out_load = !out_valid_q || !out_stall_i;
      default:   in_stall_o = 1'b1;
    endcase
  end

  assign step_d = step_done ? STEP_F0 : step_e'(step_q + 4'd1);

  dbh_fold_unit u_fold (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (fold_ctrl),
    .byte_i (cur_byte),
    .fnv_o  (fnv_val),
    .comb_o (comb_val)
  );

  // Size check against the dimensions present at the last word.
  always_comb begin
    chk_w    = dim_value(width_q);
    chk_h    = dim_value(height_q);
    prod     = DimWordW'(chk_w * chk_h);
    expected = {prod[CountW+5:0], 2'b00};
    size_err = (chk_w == '0) || (chk_h == '0) || (expected != (CountW+8)'(bytes_q));
    if (size_err) begin
      out_word_d = '{primary_hash: '0, secondary_hash: '0, byte_total: '0, size_error: 1'b1};
    end else begin
      out_word_d = '{primary_hash: fnv_val, secondary_hash: comb_val,
                     byte_total: bytes_q, size_error: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_F0;
      width_q     <= '0;
      height_q    <= '0;
      hdr_q       <= 1'b0;
      hdr_idx_q   <= '0;
      inside_q    <= 1'b0;
      bytes_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
          CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (fold_ctrl.run) begin
        step_q <= step_d;
      end
      if (fold_ctrl.init) begin
        hdr_q     <= 1'b1;
        hdr_idx_q <= '0;
        inside_q  <= 1'b1;
        bytes_q   <= '0;
      end else if (fold_ctrl.run && step_done) begin
        if (hdr_q) begin
          hdr_idx_q <= hdr_idx_q + 1'b1;
          if (hdr_idx_q == HdrLast) begin
            hdr_q <= 1'b0;
          end
        end else if (bytes_q != CountMax) begin
          bytes_q <= bytes_q + 1'b1;
        end
      end
      if (out_load) begin
        inside_q <= 1'b0;
      end
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_word_i.data_byte;
      last_q <= in_word_i.last_byte;
    end
    if (fold_ctrl.init) begin
      hdr_w_q <= dim_value(width_q);
      hdr_h_q <= dim_value(height_q);
    end
    if (out_load) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_hdr_in_msg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_q |-> inside_q)
    else $error("header phase outside a message");

  a_finish_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |-> (last_q && !hdr_q && inside_q))
    else $error("result step without a closing pixel word");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_word_q.size_error) |->
      (out_word_q.primary_hash == '0 && out_word_q.secondary_hash == '0 &&
       out_word_q.byte_total == '0))
    else $error("size error result carries nonzero fields");

  a_ok_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_word_q.size_error) |->
      (out_word_q.byte_total[1:0] == 2'b00 && out_word_q.byte_total != '0))
    else $error("good result with a count that is not whole pixels");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while held");

endmodule
